/* hdl/stip_pkg.sv */
`timescale 1ns / 1ps
// stip_pkg: types, character codes and digit decoding for the string to integer parser
// no dependencies; used by the channel interfaces and the parser top level

package stip_pkg;

  typedef logic [7:0]  char_t;
  typedef logic [4:0]  base_t;
  typedef logic [63:0] word_t;
  typedef logic [15:0] count_t;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_WS     = 3'd1,
    PH_SIGNED = 3'd2,
    PH_ZERO   = 3'd3,
    PH_XSEEN  = 3'd4,
    PH_DIGITS = 3'd5
  } phase_t;

  localparam count_t MAX_CONSUMED = 16'hFFFF;

  localparam base_t RADIX_RESET = 5'd10;
  localparam base_t BASE_DEC    = 5'd10;
  localparam base_t BASE_HEX    = 5'd16;
  localparam base_t BASE_AUTO   = 5'd0;
  localparam base_t BASE_UNARY  = 5'd1;
  localparam base_t NOT_DIGIT   = 5'd16;

  localparam char_t CH_SPACE = 8'h20;
  localparam char_t CH_TAB   = 8'h09;
  localparam char_t CH_LF    = 8'h0A;
  localparam char_t CH_CR    = 8'h0D;
  localparam char_t CH_MINUS = 8'h2D;
  localparam char_t CH_PLUS  = 8'h2B;
  localparam char_t CH_ZERO  = 8'h30;
  localparam char_t CH_NINE  = 8'h39;
  localparam char_t CH_LO_A  = 8'h61;
  localparam char_t CH_LO_F  = 8'h66;
  localparam char_t CH_LO_X  = 8'h78;
  localparam char_t CH_UP_A  = 8'h41;
  localparam char_t CH_UP_F  = 8'h46;
  localparam char_t CH_UP_X  = 8'h58;

  // digit value of a character, NOT_DIGIT for anything else
  function automatic base_t digit_of(input char_t c);
    char_t t;
    t = 8'd0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      t = c - CH_ZERO;
      return t[4:0];
    end
    if (c >= CH_LO_A && c <= CH_LO_F) begin
      t = c - CH_LO_A + 8'd10;
      return t[4:0];
    end
    if (c >= CH_UP_A && c <= CH_UP_F) begin
      t = c - CH_UP_A + 8'd10;
      return t[4:0];
    end
    return NOT_DIGIT;
  endfunction

endpackage

/* hdl/stip_ifs.sv */
`timescale 1ns / 1ps
// stip channel interfaces: character input, result output and radix write port
// depends on stip_pkg for the payload types

interface stip_in_if import stip_pkg::*; ();
  logic  valid;
  logic  ready;
  char_t character;
  logic  start_req;

  modport source (output valid, output character, output start_req, input ready);
  modport sink   (input valid, input character, input start_req, output ready);
endinterface

interface stip_out_if import stip_pkg::*; ();
  logic   valid;
  logic   ready;
  word_t  value;
  count_t consumed;

  modport source (output valid, output value, output consumed, input ready);
  modport sink   (input valid, input value, input consumed, output ready);
endinterface

interface stip_cfg_if import stip_pkg::*; ();
  logic  valid;
  logic  ready;
  base_t radix;

  modport source (output valid, output radix, input ready);
  modport sink   (input valid, input radix, output ready);
endinterface

/* hdl/string_to_integer_parser.sv */
`timescale 1ns / 1ps
// string_to_integer_parser: one character per transfer, strtol-style integer parse
// an ending character passes the input register, then the result register, waiting in the
//   first while the result register is full; throughput: one character per cycle but for
//   that wait; shift-add by a base of at most 16 lies between input and state registers
// reset: synchronous, active low; clears both stages, the parse state and sets radix to 10
// depends on stip_pkg and the interfaces in stip_ifs

module string_to_integer_parser import stip_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  stip_in_if.sink    in_bus,
  stip_out_if.source out_bus,
  stip_cfg_if.sink   cfg_bus
);

  // configuration register
  base_t radix_r;

  // input register
  logic  s1_valid_r;
  char_t s1_char_r;
  logic  s1_start_r;

  // parse state
  phase_t phase_r, phase_nxt;
  word_t  acc_r, acc_nxt;
  logic   neg_r, neg_nxt;
  base_t  base_r, base_nxt;
  count_t pos_r, pos_nxt;

  // result register
  logic   out_valid_r;
  word_t  out_value_r;
  count_t out_consumed_r;

  // step logic
  logic   start_ok, start_bad;
  phase_t cur_phase;
  base_t  cur_base;
  count_t cur_pos;
  logic   cur_neg;
  base_t  eff_base;
  base_t  dig;
  count_t pos_bump;
  word_t  mac;
  logic   is_space, is_sign, is_x;
  logic   emit;
  word_t  res_value;
  count_t res_consumed;
  logic   out_free, s1_go;

  // handshakes
  assign cfg_bus.ready = rst_n;
  // the result register frees up when empty or being taken this cycle
  assign out_free = !out_valid_r || out_bus.ready;
  // an item that gives no result never waits for the output side
  assign s1_go = s1_valid_r && (!emit || out_free);
  assign in_bus.ready = rst_n && (!s1_valid_r || s1_go);

  assign out_bus.valid    = out_valid_r;
  assign out_bus.value    = out_value_r;
  assign out_bus.consumed = out_consumed_r;

  // a start with an unusable radix reports at once and leaves the parser idle
  assign start_bad = s1_start_r && (radix_r == BASE_UNARY || radix_r > BASE_HEX);
  assign start_ok  = s1_start_r && !start_bad;

  // state seen by this character: a start opens a fresh parse
  assign cur_phase = start_ok ? PH_WS : phase_r;
  assign cur_base  = start_ok ? radix_r : base_r;
  assign cur_pos   = start_ok ? '0 : pos_r;
  assign cur_neg   = start_ok ? 1'b0 : neg_r;

  // auto radix counts as decimal until a hex prefix is seen
  assign eff_base = (cur_base == BASE_AUTO) ? BASE_DEC : cur_base;
  assign dig      = digit_of(s1_char_r);
  assign pos_bump = (cur_pos != MAX_CONSUMED) ? cur_pos + 16'd1 : cur_pos;

  assign is_space = (s1_char_r == CH_SPACE) || (s1_char_r == CH_TAB) ||
                    (s1_char_r == CH_LF) || (s1_char_r == CH_CR);
  assign is_sign  = (s1_char_r == CH_MINUS) || (s1_char_r == CH_PLUS);
  assign is_x     = (s1_char_r == CH_LO_X) || (s1_char_r == CH_UP_X);

  // accumulate, wrapping modulo 2^64; only reached with the registered state
  // shift-add over the five base bits
  assign mac = (base_r[0] ? acc_r : '0) +
               (base_r[1] ? {acc_r[62:0], 1'b0} : '0) +
               (base_r[2] ? {acc_r[61:0], 2'b0} : '0) +
               (base_r[3] ? {acc_r[60:0], 3'b0} : '0) +
               (base_r[4] ? {acc_r[59:0], 4'b0} : '0) +
               {59'd0, dig};

  // next state and result for the character in the input register
  always_comb begin
    phase_nxt    = cur_phase;
    base_nxt     = cur_base;
    pos_nxt      = cur_pos;
    neg_nxt      = cur_neg;
    acc_nxt      = start_ok ? '0 : acc_r;
    emit         = 1'b0;
    res_value    = '0;
    res_consumed = '0;
    if (start_bad) begin
      emit      = 1'b1;
      phase_nxt = PH_IDLE;
    end else begin
      unique case (cur_phase) inside
        PH_IDLE: begin
          // characters outside a string are dropped
        end
        PH_WS, PH_SIGNED: begin
          if (cur_phase == PH_WS && is_space) begin
            pos_nxt = pos_bump;
          end else if (cur_phase == PH_WS && is_sign) begin
            neg_nxt   = (s1_char_r == CH_MINUS);
            pos_nxt   = pos_bump;
            phase_nxt = PH_SIGNED;
          end else if (s1_char_r == CH_ZERO &&
                       (cur_base == BASE_AUTO || cur_base == BASE_HEX)) begin
            // leading zero may open a hex prefix
            acc_nxt   = '0;
            pos_nxt   = pos_bump;
            phase_nxt = PH_ZERO;
          end else if (dig < eff_base) begin
            base_nxt  = eff_base;
            acc_nxt   = {59'd0, dig};
            pos_nxt   = pos_bump;
            phase_nxt = PH_DIGITS;
          end else begin
            // no digits at all
            emit      = 1'b1;
            phase_nxt = PH_IDLE;
          end
        end
        PH_ZERO: begin
          if (is_x) begin
            pos_nxt   = pos_bump;
            phase_nxt = PH_XSEEN;
          end else begin
            base_nxt = eff_base;
            if (dig < eff_base) begin
              acc_nxt   = {59'd0, dig};
              pos_nxt   = pos_bump;
              phase_nxt = PH_DIGITS;
            end else begin
              emit         = 1'b1;
              res_consumed = cur_pos;
              phase_nxt    = PH_IDLE;
            end
          end
        end
        PH_XSEEN: begin
          if (dig < BASE_HEX) begin
            base_nxt  = BASE_HEX;
            acc_nxt   = {59'd0, dig};
            pos_nxt   = pos_bump;
            phase_nxt = PH_DIGITS;
          end else begin
            // the x is handed back: count stops after the zero
            emit         = 1'b1;
            res_consumed = (cur_pos == MAX_CONSUMED) ? MAX_CONSUMED : cur_pos - 16'd1;
            phase_nxt    = PH_IDLE;
          end
        end
        PH_DIGITS: begin
          if (dig < cur_base) begin
            acc_nxt = mac;
            pos_nxt = pos_bump;
          end else begin
            emit         = 1'b1;
            res_value    = cur_neg ? (64'd0 - acc_r) : acc_r;
            res_consumed = cur_pos;
            phase_nxt    = PH_IDLE;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  // radix register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RESET;
    end else if (cfg_bus.valid && cfg_bus.ready) begin
      radix_r <= cfg_bus.radix;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_bus.valid && in_bus.ready) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) begin
      s1_char_r  <= in_bus.character;
      s1_start_r <= in_bus.start_req;
    end
  end

  // parse state, moves once per character processed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      acc_r   <= '0;
      neg_r   <= 1'b0;
      base_r  <= '0;
      pos_r   <= '0;
    end else if (s1_go) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      neg_r   <= neg_nxt;
      base_r  <= base_nxt;
      pos_r   <= pos_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && emit) begin
      out_value_r    <= res_value;
      out_consumed_r <= res_consumed;
    end
  end

endmodule

/* hdl/stip_checker.sv */
`timescale 1ns / 1ps
// stip_checker: port-level checks on the string to integer parser
// depends on stip_pkg; attached to string_to_integer_parser by the bind below

module stip_checker import stip_pkg::*; (
  input logic   clk,
  input logic   rst_n,
  input logic   in_valid,
  input logic   in_ready,
  input logic   out_valid,
  input logic   out_ready,
  input word_t  value,
  input count_t consumed
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(value) && $stable(consumed))
    else $error("result changed while stalled");

  // reset empties the result register
  a_reset_clear: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // nothing counted means no digits, so the value is zero
  a_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && consumed == 16'd0 |-> value == 64'd0)
    else $error("nonzero value with no characters consumed");

  // a fresh result follows the input transfer that went through the input register
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without a preceding input transfer");

endmodule

bind string_to_integer_parser stip_checker u_stip_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_bus.valid),
  .in_ready  (in_bus.ready),
  .out_valid (out_bus.valid),
  .out_ready (out_bus.ready),
  .value     (out_bus.value),
  .consumed  (out_bus.consumed)
);
